// ===== sv/tsf_pkg.sv =====
// Shared widths, register indexes and constants of the two-mode smoothing filter.
package tsf_pkg;

  localparam int WL_W       = 6;
  localparam int ALPHA_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;
  localparam logic [WL_W-1:0]    WLEN_RESET  = 6'd16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA         = 8'd2;

endpackage

// ===== sv/tsf_in_if.sv =====
// Sample input channel: valid/ready with sample and restart flag.
interface tsf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

// ===== sv/tsf_out_if.sv =====
// Result channel: valid/ready with the filtered sample.
interface tsf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

// ===== sv/tsf_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and write data.
interface tsf_cfg_if
  import tsf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tsf_delay_mem.sv =====
// Sample delay line memory with per-entry valid bits; unwritten entries read as zero.
module tsf_delay_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [DATA_W-1:0] wr_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld_r;
  logic signed [DATA_W-1:0] rd_q_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== sv/tsf_div.sv =====
// Iterative restoring divider: signed dividend by unsigned divisor, one quotient bit a cycle.
module tsf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic [NUM_W-1:0]        quo_mag,
  output logic                    quo_neg
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] q_r;
  logic [NUM_W-1:0] q_nxt;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [NUM_W-1:0] mag;

  assign mag   = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    q_nxt   = {q_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= mag;
      den_r <= divisor;
      neg_r <= dividend[NUM_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done    = done_r;
  assign quo_mag = q_r;
  assign quo_neg = neg_r;

endmodule

// ===== sv/two_mode_smoothing_filter.sv =====
// Top level: two-mode smoothing filter (running mean or exponential smoothing).
//
// Channels: in_ch takes one beat per sample (sample, restart); out_ch gives one beat
// per sample (filtered); cfg_ch writes filter_mode (0), window_length (1), alpha (2).
// cfg_ch is always ready; write it only while no sample is in flight. Writing
// window_length empties the delay line and the running sum.
// A set restart bit clears the delay line, running sum and exponential state before
// the sample is used; the sample then loads the exponential state directly.
// Each sample steps through ST_RD (delay line read and write), ST_ACC (running sum
// and exponential update), ST_DST and ST_DWAIT (bit-serial mean divider on the
// SUM_W-bit sum, SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1) and ST_FIN; in_ch is
// ready only between items, so a new sample waits until the last one has finished.
// out_ch holds its beat until taken; a stalled receiver holds the block in its last
// step with the finished result waiting, and no new sample is taken meanwhile.
// Reset (rst_n low, synchronous) restores register defaults (mode 0, window 16,
// alpha 0.5), empties the delay line and arms the exponential filter's first load.
module two_mode_smoothing_filter
  import tsf_pkg::*;
#(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  tsf_in_if.sink  in_ch,
  tsf_out_if.source out_ch,
  tsf_cfg_if.sink cfg_ch
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int OS_W   = SLOT_W + 1;
  localparam int DIV_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (WL_W > DIV_W) ? WL_W : DIV_W;
  localparam int SUM_W  = SB + $clog2(MAX_WINDOW) + 1;
  localparam int Y_W    = SB + FRAC_W;
  localparam int PROD_W = Y_W + ALPHA_W + 2;

  localparam logic [CMP_W-1:0] MW_C     = CMP_W'(MAX_WINDOW);
  localparam logic [OS_W-1:0]  MW_OS    = OS_W'(MAX_WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
  localparam logic [SUM_W-1:0] SAT_HI   = SUM_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] SAT_LO_M = SUM_W'(64'd1 << (SB - 1));
  localparam logic signed [SB-1:0] S_HI = SB'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB-1:0] S_LO = SB'(64'd1 << (SB - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_DST,
    ST_DWAIT,
    ST_FIN
  } state_t;

  state_t state_r;

  logic               mode_r;
  logic [WL_W-1:0]    wlen_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic [SLOT_W-1:0]       slot_r;
  logic [SLOT_W-1:0]       slot_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [Y_W-1:0]   y_r;
  logic signed [Y_W-1:0]   y_nxt;
  logic                    first_r;
  logic signed [SB-1:0]    x_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                  out_valid_r;
  logic signed [SB-1:0]  out_filtered_r;

  logic                  accept;
  logic                  cfg_we;
  logic                  mem_clear;
  logic [CMP_W-1:0]      wl_ext;
  logic [CMP_W-1:0]      w_ext;
  logic [DIV_W-1:0]      w_eff;
  logic [ALPHA_W-1:0]    a_eff;
  logic [OS_W-1:0]       os_sum;
  logic [SLOT_W-1:0]     old_slot;
  logic signed [SB-1:0]  old_sample;
  logic signed [Y_W:0]   diff;
  logic signed [ALPHA_W:0] a_s;
  logic signed [PROD_W-1:0] prod_c;

  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      quo_mag;
  logic                  quo_neg;
  logic signed [SB-1:0]  mean_c;
  logic signed [SB-1:0]  result_c;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;
  assign mem_clear    = (accept && in_ch.restart) ||
                        (cfg_we && cfg_ch.index == REG_WINDOW_LENGTH);

  always_comb begin
    wl_ext = CMP_W'(wlen_r);
    if (wl_ext == '0) begin
      w_ext = CMP_W'(1);
    end else if (wl_ext > MW_C) begin
      w_ext = MW_C;
    end else begin
      w_ext = wl_ext;
    end
    w_eff = DIV_W'(w_ext);
    a_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  end

  always_comb begin
    os_sum   = OS_W'(slot_r) + MW_OS - OS_W'(w_eff);
    old_slot = (os_sum >= MW_OS) ? SLOT_W'(os_sum - MW_OS) : SLOT_W'(os_sum);
    slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
    sum_nxt  = sum_r - SUM_W'(old_sample) + SUM_W'(x_r);
  end

  always_comb begin
    diff   = $signed({x_r[SB-1], x_r, {FRAC_W{1'b0}}}) - (Y_W + 1)'(y_r);
    a_s    = $signed({1'b0, a_eff});
    prod_c = diff * a_s;
    if (first_r) begin
      y_nxt = $signed({x_r, {FRAC_W{1'b0}}});
    end else begin
      y_nxt = y_r + Y_W'(prod_r >>> FRAC_W);
    end
  end

  always_comb begin
    if (!quo_neg) begin
      mean_c = (quo_mag > SAT_HI) ? S_HI : quo_mag[SB-1:0];
    end else begin
      mean_c = (quo_mag > SAT_LO_M) ? S_LO : SB'(0) - quo_mag[SB-1:0];
    end
    result_c = mode_r ? y_r[Y_W-1:FRAC_W] : mean_c;
  end

  assign div_start = (state_r == ST_DST);

  tsf_delay_mem #(
    .DEPTH  (MAX_WINDOW),
    .DATA_W (SB)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mem_clear),
    .rd_en   (state_r == ST_RD),
    .rd_addr (old_slot),
    .rd_data (old_sample),
    .wr_en   (state_r == ST_RD),
    .wr_addr (slot_r),
    .wr_data (x_r)
  );

  tsf_div #(
    .NUM_W (SUM_W),
    .DEN_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (w_eff),
    .done     (div_done),
    .quo_mag  (quo_mag),
    .quo_neg  (quo_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      wlen_r  <= WLEN_RESET;
      alpha_r <= ALPHA_RESET;
      slot_r  <= '0;
      sum_r   <= '0;
      y_r     <= '0;
      first_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_ch.index)
          REG_FILTER_MODE: begin
            mode_r <= cfg_ch.data[0];
          end
          REG_WINDOW_LENGTH: begin
            wlen_r <= cfg_ch.data[WL_W-1:0];
            slot_r <= '0;
            sum_r  <= '0;
          end
          REG_ALPHA: begin
            alpha_r <= cfg_ch.data[ALPHA_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept && in_ch.restart) begin
        slot_r  <= '0;
        sum_r   <= '0;
        y_r     <= '0;
        first_r <= 1'b1;
      end
      if (state_r == ST_ACC) begin
        slot_r  <= slot_nxt;
        sum_r   <= sum_nxt;
        y_r     <= y_nxt;
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_ch.sample;
    end
    if (state_r == ST_RD) begin
      prod_r <= prod_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= ST_DST;
        end
        ST_DST: begin
          state_r <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r    <= 1'b1;
            out_filtered_r <= result_c;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filtered_r;

endmodule

// ===== test/two_mode_smoothing_filter_test.sv =====
// Self-checking testbench for the two-mode smoothing filter: edge cases, then random records.
module two_mode_smoothing_filter_test;
  import tsf_pkg::*;

  localparam int DEPTH = 32;
  localparam int SBITS = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'd255;
  localparam logic signed [SBITS-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SBITS-1:0] S_MIN = 16'sh8000;

  logic clk = 1'b0;
  logic rst_n;

  tsf_in_if  #(.SAMPLE_BITS(SBITS)) in_ch ();
  tsf_out_if #(.SAMPLE_BITS(SBITS)) out_ch ();
  tsf_cfg_if                        cfg_ch ();

  two_mode_smoothing_filter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  logic signed [SBITS-1:0] window_buf [DEPTH];
  logic [4:0]              wslot;
  longint                  win_sum;
  longint                  ema_acc;
  bit                      ema_first;
  logic                    pick_ema;
  logic [WL_W-1:0]         win_len;
  logic [ALPHA_W-1:0]      alpha_q16;

  logic signed [SBITS-1:0] expected_filtered [$];
  int errors = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  function automatic void clear_window();
    foreach (window_buf[i]) window_buf[i] = '0;
    wslot = '0;
    win_sum = 0;
  endfunction

  function automatic void reset_model();
    pick_ema = 1'b0;
    win_len = WLEN_RESET;
    alpha_q16 = ALPHA_RESET;
    clear_window();
    ema_acc = 0;
    ema_first = 1'b1;
  endfunction

  function automatic logic signed [SBITS-1:0] clamp16(input longint v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return v[SBITS-1:0];
  endfunction

  function automatic logic signed [SBITS-1:0] smooth_next(input logic signed [SBITS-1:0] x,
                                                          input logic restart_bit);
    int     eff_w;
    int     oldest;
    longint eff_a;
    longint avg;
    longint diff;
    if (restart_bit) begin
      clear_window();
      ema_acc = 0;
      ema_first = 1'b1;
    end
    eff_w = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
    eff_a = (alpha_q16 > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q16);
    oldest = (int'(wslot) + DEPTH - eff_w) % DEPTH;
    win_sum = win_sum - longint'(window_buf[oldest]) + longint'(x);
    window_buf[wslot] = x;
    wslot = wslot + 5'd1;
    avg = win_sum / longint'(eff_w);
    if (ema_first) begin
      ema_acc = longint'(x) <<< FRAC_W;
      ema_first = 1'b0;
    end else begin
      diff = (longint'(x) <<< FRAC_W) - ema_acc;
      ema_acc = ema_acc + ((diff * eff_a) >>> FRAC_W);
    end
    return pick_ema ? clamp16(ema_acc >>> FRAC_W) : clamp16(avg);
  endfunction

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1: return SBITS'($signed($urandom_range(0, 16)) - 8);
      default: return SBITS'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [SBITS-1:0] s, input logic restart_bit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= SBITS'($urandom);
      in_ch.restart <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.restart <= restart_bit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_filtered.push_back(smooth_next(s, restart_bit));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_filtered.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_FILTER_MODE: pick_ema = data[0];
      REG_WINDOW_LENGTH: begin
        win_len = data[WL_W-1:0];
        clear_window();
      end
      REG_ALPHA: alpha_q16 = data[ALPHA_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [WL_W-1:0]       w;
    logic [ALPHA_W-1:0]    a;
    logic [CFG_DATA_W-1:0] upper;
    cfg_write(REG_FILTER_MODE, $urandom);
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0: w = '0;
        1: w = WL_W'(1);
        2: w = WL_W'(DEPTH);
        3: w = WL_W'($urandom_range(DEPTH + 1, 63));
        default: w = WL_W'($urandom_range(2, DEPTH - 1));
      endcase
      upper = $urandom_range(0, 1) ? ($urandom & 32'hffff_ffc0) : 32'd0;
      cfg_write(REG_WINDOW_LENGTH, upper | CFG_DATA_W'(w));
    end
    case ($urandom_range(0, 5))
      0: a = '0;
      1: a = ALPHA_ONE;
      2: a = ALPHA_W'($urandom_range(65537, 131071));
      3: a = ALPHA_W'(1);
      default: a = ALPHA_W'($urandom_range(1, 65535));
    endcase
    upper = $urandom_range(0, 1) ? ($urandom & 32'hfffe_0000) : 32'd0;
    cfg_write(REG_ALPHA, upper | CFG_DATA_W'(a));
  endtask

  task automatic run_records(input int n);
    int stop_at;
    int len;
    stop_at = samples_sent + n;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) random_config();
      len = $urandom_range(1, 48);
      for (int i = 0; i < len; i++) begin
        push_sample(pick_sample(),
                    (i == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 99) < 2);
      end
    end
    drain();
  endtask

  task automatic test_mean_edges();
    push_sample(S_MAX, 1'b1);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    drain();
  endtask

  task automatic test_register_edges();
    cfg_write(REG_WINDOW_LENGTH, 32'd0);
    push_sample(16'sd1234, 1'b0);
    push_sample(-16'sd1, 1'b0);
    cfg_write(REG_WINDOW_LENGTH, 32'd63);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    cfg_write(REG_WINDOW_LENGTH, 32'hffff_ffc1);
    push_sample(-16'sd777, 1'b0);
    cfg_write(REG_SPARE, 32'h0000_0001);
    cfg_write(REG_TOP, 32'hffff_ffff);
    push_sample(16'sd5, 1'b0);
    cfg_write(REG_FILTER_MODE, 32'hffff_ffff);
    cfg_write(REG_ALPHA, 32'd0);
    push_sample(S_MIN, 1'b1);
    push_sample(S_MAX, 1'b0);
    push_sample(16'sd100, 1'b0);
    cfg_write(REG_ALPHA, 32'h0001_0000);
    push_sample(S_MAX, 1'b0);
    push_sample(-16'sd2, 1'b0);
    cfg_write(REG_ALPHA, 32'h0001_ffff);
    push_sample(S_MIN, 1'b0);
    cfg_write(REG_ALPHA, 32'hfffb_8001);
    push_sample(S_MAX, 1'b0);
    cfg_write(REG_ALPHA, 32'd1);
    push_sample(S_MIN, 1'b0);
    cfg_write(REG_FILTER_MODE, 32'd0);
  endtask

  task automatic test_idle_phases();
    int send_pcts [4] = '{0, 75, 0, 20};
    int stall_pcts [4] = '{0, 0, 75, 20};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      run_records(430);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_config();
    hold_left = 400;
    for (int i = 0; i < 12; i++) push_sample(pick_sample(), i == 0);
    drain();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_beat
    logic signed [SBITS-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (expected_filtered.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] filtered beat %0d with nothing outstanding", $time, out_ch.filtered);
        end
      end else begin
        want = expected_filtered.pop_front();
        if (out_ch.filtered !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] filtered mismatch: expected %0d, got %0d",
                     $time, want, out_ch.filtered);
          end
        end
      end
    end
  end

  initial begin
    #16_000_000;
    $display("Run exceeded its time budget with %0d results outstanding",
             expected_filtered.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_mean_edges();
    test_register_edges();
    test_backpressure();
    test_idle_phases();
    drain();
    repeat (40) @(posedge clk);
    errors += expected_filtered.size();
    $display("Sent %0d samples, checked %0d results, made %0d register writes",
             samples_sent, beats_checked, cfg_writes);
    $display("Both modes, window and alpha extremes, four idle mixes, long hold; %0d errors",
             errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsf_pkg.sv
sv/tsf_in_if.sv
sv/tsf_out_if.sv
sv/tsf_cfg_if.sv
sv/tsf_delay_mem.sv
sv/tsf_div.sv
sv/two_mode_smoothing_filter.sv
test/two_mode_smoothing_filter_test.sv
